@@ hw/rtl/ip_range_access_filter_assert.svh @@
// assertion macros for the top rtl file
`ifndef IP_RANGE_ACCESS_FILTER_ASSERT_SVH
`define IP_RANGE_ACCESS_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IPRAF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ipraf assertion failed");

// next-cycle implication, disabled in reset
`define IPRAF_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ipraf assertion failed");

`endif

@@ hw/rtl/ipraf_pkg.sv @@
// shared constants, codes and types of the ip range access filter
package ipraf_pkg;

  localparam int DefBlockRanges     = 4096;
  localparam int DefExceptionRanges = 64;
  localparam int DefAdminRanges     = 64;
  localparam int DefConditionEntries = 64;

  // request codes
  localparam logic [2:0] REQ_LOAD_BLOCK = 3'd0;
  localparam logic [2:0] REQ_LOAD_EXC   = 3'd1;
  localparam logic [2:0] REQ_LOAD_ADMIN = 3'd2;
  localparam logic [2:0] REQ_LOAD_COND  = 3'd3;
  localparam logic [2:0] REQ_CHECK      = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  // check reasons
  localparam logic [2:0] RSN_EXCEPTION = 3'd0;
  localparam logic [2:0] RSN_FILTER_OFF = 3'd1;
  localparam logic [2:0] RSN_BYPASS    = 3'd2;
  localparam logic [2:0] RSN_COND_OK   = 3'd3;
  localparam logic [2:0] RSN_ADMIN     = 3'd4;
  localparam logic [2:0] RSN_PATCH     = 3'd5;
  localparam logic [2:0] RSN_COND      = 3'd6;
  localparam logic [2:0] RSN_NO_ENTRY  = 3'd7;

  // load status
  localparam logic [1:0] LS_OK    = 2'd0;
  localparam logic [1:0] LS_FULL  = 2'd1;
  localparam logic [1:0] LS_DUP   = 2'd2;
  localparam logic [1:0] LS_ORDER = 2'd3;

  // condition key classes
  localparam logic [1:0] KEY_COUNTRY = 2'd0;
  localparam logic [1:0] KEY_DEFAULT = 2'd1;
  localparam logic [1:0] KEY_NOMATCH = 2'd2;
  localparam logic [1:0] KEY_BAD     = 2'd3;

  // config register indexes
  localparam logic [1:0] CFG_ADMIN_CHECK = 2'd0;
  localparam logic [1:0] CFG_PATCH       = 2'd1;
  localparam logic [1:0] CFG_FILTER      = 2'd2;
  localparam logic [1:0] CFG_ADMIN_LEVEL = 2'd3;

  localparam logic [15:0] NO_COUNTRY = 16'h5A5A;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_ADM_GO, ST_ADM_WAIT, ST_EXC_GO, ST_EXC_WAIT,
    ST_BLK_GO, ST_BLK_WAIT, ST_CSCAN_RD, ST_CSCAN_CMP, ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {SR_IDLE, SR_PROBE, SR_CMP} srch_state_t;

  // result of one range search
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [15:0] aux;
  } srch_res_t;

endpackage

@@ hw/rtl/ipraf_ram.sv @@
// generic simple dual-port ram with registered read
module ipraf_ram import ipraf_pkg::*; #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ipraf_bsearch.sv @@
// iterative binary search over a sorted range table, reading in SR_PROBE and comparing in SR_CMP
module ipraf_bsearch import ipraf_pkg::*; #(
  parameter int SW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [SW-1:0] n,
  input  logic [31:0]   addr,
  output logic [SW-1:0] rd_addr,
  input  logic [31:0]   rd_start,
  input  logic [31:0]   rd_end,
  input  logic [15:0]   rd_aux,
  output srch_res_t     res
);

  srch_state_t st_r, st_nxt;
  logic [SW-1:0] lo_r, hi_r, mid;
  logic [31:0]   a_r, cand_end_r;
  logic [15:0]   cand_aux_r;
  logic          cand_vld_r;

  // probe index
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_addr = mid;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and result
  always_comb begin
    st_nxt   = st_r;
    res.done = 1'b0;
    res.hit  = cand_vld_r && (a_r <= cand_end_r);
    res.aux  = cand_aux_r;
    case (st_r)
      SR_IDLE: begin
        if (go) st_nxt = SR_PROBE;
      end
      SR_PROBE: begin
        if (lo_r < hi_r) begin
          st_nxt = SR_CMP;
        end else begin
          res.done = 1'b1;
          st_nxt   = SR_IDLE;
        end
      end
      SR_CMP: st_nxt = SR_PROBE;
      default: st_nxt = SR_IDLE;
    endcase
  end

  // search window and last candidate at or below the address
  always_ff @(posedge clk) begin
    if (st_r == SR_IDLE && go) begin
      lo_r       <= '0;
      hi_r       <= n;
      a_r        <= addr;
      cand_vld_r <= 1'b0;
    end else if (st_r == SR_CMP) begin
      if (rd_start <= a_r) begin
        lo_r       <= mid + SW'(1);
        cand_end_r <= rd_end;
        cand_aux_r <= rd_aux;
        cand_vld_r <= 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
  end

endmodule

@@ hw/rtl/ip_range_access_filter.sv @@
// Clear, unused requests and range loads finish after the dispatch state.
// Condition load: linear scan of the condition ram (skipped for a bad key class).
// Check: admin, exception and block searches, then the condition scan;
// a search of n ranges takes at most floor(log2(n)) + 1 probes.
// One item at a time: busy covers it, the next start can be taken while the strobe is high,
// the strobe lasts one cycle and the receiver cannot stall; sync reset zeroes counts and config.
module ip_range_access_filter import ipraf_pkg::*; #(
  parameter int BLOCK_RANGES      = DefBlockRanges,
  parameter int EXCEPTION_RANGES  = DefExceptionRanges,
  parameter int ADMIN_RANGES      = DefAdminRanges,
  parameter int CONDITION_ENTRIES = DefConditionEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [31:0] in_range_last,
  input  logic [15:0] in_country,
  input  logic [1:0]  in_key_class,
  input  logic        in_block_flag,
  input  logic        in_block_old_users,
  input  logic        in_new_user,
  input  logic signed [7:0] in_auth_level,
  input  logic        in_bypass,
  output logic        out_valid,
  output logic        out_allowed,
  output logic [2:0]  out_reason,
  output logic [15:0] out_found_country,
  output logic [1:0]  out_load_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

`include "ip_range_access_filter_assert.svh"

  localparam int BAW = (BLOCK_RANGES > 1) ? $clog2(BLOCK_RANGES) : 1;
  localparam int EAW = (EXCEPTION_RANGES > 1) ? $clog2(EXCEPTION_RANGES) : 1;
  localparam int AAW = (ADMIN_RANGES > 1) ? $clog2(ADMIN_RANGES) : 1;
  localparam int CAW = (CONDITION_ENTRIES > 1) ? $clog2(CONDITION_ENTRIES) : 1;
  localparam int BCW = $clog2(BLOCK_RANGES + 1);
  localparam int ECW = $clog2(EXCEPTION_RANGES + 1);
  localparam int ACW = $clog2(ADMIN_RANGES + 1);
  localparam int CCW = $clog2(CONDITION_ENTRIES + 1);
  localparam int SW0 = (BCW > ECW) ? BCW : ECW;
  localparam int SW  = (SW0 > ACW) ? SW0 : ACW;

  state_t state_r, state_nxt;

  // config registers
  logic adm_chk_r, patch_r, filter_r;
  logic signed [7:0] adm_level_r;

  // table fill counts and last range ends
  logic [BCW-1:0] blk_cnt_r;
  logic [ECW-1:0] exc_cnt_r;
  logic [ACW-1:0] adm_cnt_r;
  logic [CCW-1:0] cond_cnt_r;
  logic [31:0]    blk_last_r, exc_last_r, adm_last_r;

  // latched input word
  logic [2:0]  req_r;
  logic [31:0] addr_r, last_r;
  logic [15:0] cc_r;
  logic [1:0]  cls_r;
  logic        blk_flag_r, old_r, newu_r, byp_r;
  logic signed [7:0] auth_r;

  // search and scan results
  logic        adm_hit_r, exc_hit_r, blk_hit_r;
  logic [15:0] blk_cc_r;
  logic [CCW-1:0] idx_r;
  logic        a_fnd_r, b_fnd_r;
  logic [1:0]  a_flg_r, b_flg_r;

  // result word
  logic        out_valid_r, out_allowed_r;
  logic [2:0]  out_reason_r;
  logic [15:0] out_found_r;
  logic [1:0]  out_status_r;

  // ram ports
  logic [79:0] blk_rdata;
  logic [63:0] exc_rdata, adm_rdata;
  logic [19:0] cond_rdata;
  logic        blk_we, exc_we, adm_we, cond_we;

  // search unit ports
  logic          srch_go;
  logic [SW-1:0] srch_n, srch_raddr;
  logic [31:0]   srch_start, srch_end;
  logic [15:0]   srch_aux;
  srch_res_t     srch_res;

  // range load checks
  logic blk_full, exc_full, adm_full, cond_full, range_rev;
  logic blk_ord, exc_ord, adm_ord;
  logic [1:0] blk_st, exc_st, adm_st;

  // keys and decision
  logic [17:0] key_a, key_b;
  logic        dec_allow;
  logic [2:0]  dec_reason;
  logic [1:0]  cond_st;
  logic [1:0]  sel_flg;
  logic        sel_fnd;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_allowed       = out_allowed_r;
  assign out_reason        = out_reason_r;
  assign out_found_country = out_found_r;
  assign out_load_status   = out_status_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adm_chk_r   <= 1'b0;
      patch_r     <= 1'b0;
      filter_r    <= 1'b0;
      adm_level_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADMIN_CHECK: adm_chk_r   <= cfg_wdata[0];
        CFG_PATCH:       patch_r     <= cfg_wdata[0];
        CFG_FILTER:      filter_r    <= cfg_wdata[0];
        CFG_ADMIN_LEVEL: adm_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // load checks, full first, then reversed, then out of order
  assign blk_full  = (blk_cnt_r >= BCW'(BLOCK_RANGES));
  assign exc_full  = (exc_cnt_r >= ECW'(EXCEPTION_RANGES));
  assign adm_full  = (adm_cnt_r >= ACW'(ADMIN_RANGES));
  assign cond_full = (cond_cnt_r >= CCW'(CONDITION_ENTRIES));
  assign range_rev = (last_r < addr_r);
  assign blk_ord   = (blk_cnt_r != '0) && (addr_r <= blk_last_r);
  assign exc_ord   = (exc_cnt_r != '0) && (addr_r <= exc_last_r);
  assign adm_ord   = (adm_cnt_r != '0) && (addr_r <= adm_last_r);
  assign blk_st = blk_full ? LS_FULL : ((range_rev || blk_ord) ? LS_ORDER : LS_OK);
  assign exc_st = exc_full ? LS_FULL : ((range_rev || exc_ord) ? LS_ORDER : LS_OK);
  assign adm_st = adm_full ? LS_FULL : ((range_rev || adm_ord) ? LS_ORDER : LS_OK);

  assign blk_we = (state_r == ST_DISPATCH) && (req_r == REQ_LOAD_BLOCK) && (blk_st == LS_OK);
  assign exc_we = (state_r == ST_DISPATCH) && (req_r == REQ_LOAD_EXC) && (exc_st == LS_OK);
  assign adm_we = (state_r == ST_DISPATCH) && (req_r == REQ_LOAD_ADMIN) && (adm_st == LS_OK);

  // condition keys
  always_comb begin
    if (req_r == REQ_CHECK) begin
      key_a = blk_hit_r ? {KEY_COUNTRY, blk_cc_r} : {KEY_NOMATCH, 16'h0};
      key_b = {KEY_DEFAULT, 16'h0};
    end else begin
      key_a = {cls_r, (cls_r == KEY_COUNTRY) ? cc_r : 16'h0};
      key_b = key_a;
    end
  end

  assign cond_st = (cls_r == KEY_BAD) ? LS_ORDER :
                   (a_fnd_r ? LS_DUP : (cond_full ? LS_FULL : LS_OK));
  assign cond_we = (state_r == ST_DECIDE) && (req_r == REQ_LOAD_COND) && (cond_st == LS_OK);

  // check decision chain
  assign sel_fnd = a_fnd_r || b_fnd_r;
  assign sel_flg = a_fnd_r ? a_flg_r : b_flg_r;
  always_comb begin
    dec_allow  = 1'b0;
    dec_reason = RSN_EXCEPTION;
    if (adm_chk_r && (auth_r == adm_level_r) && !adm_hit_r) begin
      dec_reason = RSN_ADMIN;
    end else if (exc_hit_r) begin
      dec_allow  = 1'b1;
      dec_reason = RSN_EXCEPTION;
    end else if (patch_r) begin
      dec_reason = RSN_PATCH;
    end else if (!filter_r) begin
      dec_allow  = 1'b1;
      dec_reason = RSN_FILTER_OFF;
    end else if (byp_r) begin
      dec_allow  = 1'b1;
      dec_reason = RSN_BYPASS;
    end else if (!sel_fnd) begin
      dec_reason = RSN_NO_ENTRY;
    end else if (sel_flg[1] && (sel_flg[0] || newu_r)) begin
      dec_reason = RSN_COND;
    end else begin
      dec_allow  = 1'b1;
      dec_reason = RSN_COND_OK;
    end
  end

  // tables
  ipraf_ram #(.Width(80), .Depth(BLOCK_RANGES)) u_blk_ram (
    .clk, .we(blk_we), .waddr(blk_cnt_r[BAW-1:0]), .wdata({addr_r, last_r, cc_r}),
    .raddr(srch_raddr[BAW-1:0]), .rdata(blk_rdata)
  );
  ipraf_ram #(.Width(64), .Depth(EXCEPTION_RANGES)) u_exc_ram (
    .clk, .we(exc_we), .waddr(exc_cnt_r[EAW-1:0]), .wdata({addr_r, last_r}),
    .raddr(srch_raddr[EAW-1:0]), .rdata(exc_rdata)
  );
  ipraf_ram #(.Width(64), .Depth(ADMIN_RANGES)) u_adm_ram (
    .clk, .we(adm_we), .waddr(adm_cnt_r[AAW-1:0]), .wdata({addr_r, last_r}),
    .raddr(srch_raddr[AAW-1:0]), .rdata(adm_rdata)
  );
  ipraf_ram #(.Width(20), .Depth(CONDITION_ENTRIES)) u_cond_ram (
    .clk, .we(cond_we), .waddr(cond_cnt_r[CAW-1:0]),
    .wdata({key_a, blk_flag_r, old_r}),
    .raddr(idx_r[CAW-1:0]), .rdata(cond_rdata)
  );

  // route the shared search unit to the table being searched
  always_comb begin
    srch_go    = 1'b0;
    srch_n     = SW'(blk_cnt_r);
    srch_start = blk_rdata[79:48];
    srch_end   = blk_rdata[47:16];
    srch_aux   = blk_rdata[15:0];
    case (state_r)
      ST_ADM_GO, ST_ADM_WAIT: begin
        srch_go    = (state_r == ST_ADM_GO);
        srch_n     = SW'(adm_cnt_r);
        srch_start = adm_rdata[63:32];
        srch_end   = adm_rdata[31:0];
        srch_aux   = 16'h0;
      end
      ST_EXC_GO, ST_EXC_WAIT: begin
        srch_go    = (state_r == ST_EXC_GO);
        srch_n     = SW'(exc_cnt_r);
        srch_start = exc_rdata[63:32];
        srch_end   = exc_rdata[31:0];
        srch_aux   = 16'h0;
      end
      ST_BLK_GO: srch_go = 1'b1;
      default: ;
    endcase
  end

  ipraf_bsearch #(.SW(SW)) u_bsearch (
    .clk, .rst_n, .go(srch_go), .n(srch_n), .addr(addr_r), .rd_addr(srch_raddr),
    .rd_start(srch_start), .rd_end(srch_end), .rd_aux(srch_aux), .res(srch_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (req_r)
          REQ_LOAD_COND: state_nxt = (cls_r == KEY_BAD) ? ST_DECIDE : ST_CSCAN_RD;
          REQ_CHECK:     state_nxt = ST_ADM_GO;
          default:       state_nxt = ST_IDLE;
        endcase
      end
      ST_ADM_GO:   state_nxt = ST_ADM_WAIT;
      ST_ADM_WAIT: begin
        if (srch_res.done) state_nxt = ST_EXC_GO;
      end
      ST_EXC_GO:   state_nxt = ST_EXC_WAIT;
      ST_EXC_WAIT: begin
        if (srch_res.done) state_nxt = ST_BLK_GO;
      end
      ST_BLK_GO:   state_nxt = ST_BLK_WAIT;
      ST_BLK_WAIT: begin
        if (srch_res.done) state_nxt = ST_CSCAN_RD;
      end
      ST_CSCAN_RD:  state_nxt = (idx_r >= cond_cnt_r) ? ST_DECIDE : ST_CSCAN_CMP;
      ST_CSCAN_CMP: state_nxt = ST_CSCAN_RD;
      ST_DECIDE:    state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // input word latch, search results and condition scan
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r      <= in_req_type;
      addr_r     <= in_address;
      last_r     <= in_range_last;
      cc_r       <= in_country;
      cls_r      <= in_key_class;
      blk_flag_r <= in_block_flag;
      old_r      <= in_block_old_users;
      newu_r     <= in_new_user;
      auth_r     <= in_auth_level;
      byp_r      <= in_bypass;
    end
    if (state_r == ST_DISPATCH) begin
      idx_r   <= '0;
      a_fnd_r <= 1'b0;
      b_fnd_r <= 1'b0;
    end
    if (state_r == ST_ADM_WAIT && srch_res.done) adm_hit_r <= srch_res.hit;
    if (state_r == ST_EXC_WAIT && srch_res.done) exc_hit_r <= srch_res.hit;
    if (state_r == ST_BLK_WAIT && srch_res.done) begin
      blk_hit_r <= srch_res.hit;
      blk_cc_r  <= srch_res.aux;
    end
    if (state_r == ST_CSCAN_CMP) begin
      idx_r <= idx_r + CCW'(1);
      if (cond_rdata[19:2] == key_a) begin
        a_fnd_r <= 1'b1;
        a_flg_r <= cond_rdata[1:0];
      end
      if (cond_rdata[19:2] == key_b) begin
        b_fnd_r <= 1'b1;
        b_flg_r <= cond_rdata[1:0];
      end
    end
  end

  // fill counts and last ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r  <= '0;
      exc_cnt_r  <= '0;
      adm_cnt_r  <= '0;
      cond_cnt_r <= '0;
    end else begin
      if (state_r == ST_DISPATCH && req_r == REQ_CLEAR) begin
        blk_cnt_r  <= '0;
        exc_cnt_r  <= '0;
        adm_cnt_r  <= '0;
        cond_cnt_r <= '0;
      end
      if (blk_we)  blk_cnt_r  <= blk_cnt_r + BCW'(1);
      if (exc_we)  exc_cnt_r  <= exc_cnt_r + ECW'(1);
      if (adm_we)  adm_cnt_r  <= adm_cnt_r + ACW'(1);
      if (cond_we) cond_cnt_r <= cond_cnt_r + CCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_last_r <= last_r;
    if (exc_we) exc_last_r <= last_r;
    if (adm_we) adm_last_r <= last_r;
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_nxt == ST_IDLE) && (state_r != ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DISPATCH) begin
      out_allowed_r <= 1'b0;
      out_reason_r  <= RSN_EXCEPTION;
      out_found_r   <= 16'h0;
      case (req_r)
        REQ_LOAD_BLOCK: out_status_r <= blk_st;
        REQ_LOAD_EXC:   out_status_r <= exc_st;
        REQ_LOAD_ADMIN: out_status_r <= adm_st;
        default:        out_status_r <= LS_OK;
      endcase
    end else if (state_r == ST_DECIDE) begin
      if (req_r == REQ_CHECK) begin
        out_allowed_r <= dec_allow;
        out_reason_r  <= dec_reason;
        out_found_r   <= blk_hit_r ? blk_cc_r : NO_COUNTRY;
        out_status_r  <= LS_OK;
      end else begin
        out_status_r  <= cond_st;
      end
    end
  end

  // checks
  `IPRAF_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `IPRAF_ASSERT_IMP(a_out_idle, out_valid, !busy)
  `IPRAF_ASSERT_IMP(a_out_after_work, out_valid, $past(busy))
  `IPRAF_ASSERT_IMP(a_one_write, blk_we || exc_we || adm_we || cond_we,
                    $onehot({blk_we, exc_we, adm_we, cond_we}))

endmodule

@@ tb/ip_range_access_filter_tb.sv @@
// self-checking testbench of the ip range access filter with its own decision predictor
`timescale 1ns / 100ps

module ip_range_access_filter_tb;
  import ipraf_pkg::*;

  localparam int BLK_N = DefBlockRanges;
  localparam int RNG_N = DefExceptionRanges;
  localparam int COND_N = DefConditionEntries;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RND_PHASES = 10;
  localparam int RND_PER_PHASE = 55;
  localparam int FILL_BLK = 150;

  typedef struct {
    logic [2:0]        req;
    logic [31:0]       addr;
    logic [31:0]       rlast;
    logic [15:0]       cc;
    logic [1:0]        cls;
    logic              blk;
    logic              old;
    logic              newu;
    logic signed [7:0] auth;
    logic              byp;
  } req_word_t;

  typedef struct {
    logic        allowed;
    logic [2:0]  reason;
    logic [15:0] found;
    logic [1:0]  status;
  } verdict_t;

  typedef struct {
    req_word_t w;
    bit        typed;
    verdict_t  v;
  } dir_row_t;

  logic clk, rst_n;
  logic start, busy;
  logic [2:0] in_req_type;
  logic [31:0] in_address, in_range_last;
  logic [15:0] in_country;
  logic [1:0] in_key_class;
  logic in_block_flag, in_block_old_users, in_new_user, in_bypass;
  logic signed [7:0] in_auth_level;
  logic out_valid, out_allowed;
  logic [2:0] out_reason;
  logic [15:0] out_found_country;
  logic [1:0] out_load_status;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  // predicted state: block list, exception (0) and admin (1) lists, conditions
  logic [31:0] blk_lo [BLK_N];
  logic [31:0] blk_hi [BLK_N];
  logic [15:0] blk_cc [BLK_N];
  int blk_cnt;
  logic [31:0] rng_lo [2][RNG_N];
  logic [31:0] rng_hi [2][RNG_N];
  int rng_cnt [2];
  logic [1:0]  cond_cls [COND_N];
  logic [15:0] cond_cc [COND_N];
  logic        cond_blk [COND_N];
  logic        cond_old [COND_N];
  int cond_cnt;
  logic r_admin, r_patch, r_filter;
  logic [7:0] r_level;

  verdict_t verdict_q[$];
  int errors;
  int cycles = 0;

  ip_range_access_filter uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int blk_find(logic [31:0] a);
    for (int i = 0; i < blk_cnt; i++)
      if (blk_lo[i] <= a && a <= blk_hi[i]) return i;
    return -1;
  endfunction

  function automatic bit rng_find(int t, logic [31:0] a);
    for (int i = 0; i < rng_cnt[t]; i++)
      if (rng_lo[t][i] <= a && a <= rng_hi[t][i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int cond_find(logic [1:0] cls, logic [15:0] cc);
    logic [15:0] kcc;
    kcc = (cls == KEY_COUNTRY) ? cc : 16'd0;
    for (int i = 0; i < cond_cnt; i++)
      if (cond_cls[i] == cls && cond_cc[i] == kcc) return i;
    return -1;
  endfunction

  // next free address of a table, 2**32 when it can take no more ordered ranges
  function automatic longint next_free(int t);
    if (t == 2) return blk_cnt ? longint'(blk_hi[blk_cnt-1]) + 1 : 0;
    return rng_cnt[t] ? longint'(rng_hi[t][rng_cnt[t]-1]) + 1 : 0;
  endfunction

  // verdict of one word, updating the predicted tables
  function automatic verdict_t filter_verdict(req_word_t w);
    verdict_t v;
    int hit, e, t;
    v = '{1'b0, RSN_EXCEPTION, 16'd0, LS_OK};
    case (w.req)
      REQ_LOAD_BLOCK: begin
        if (blk_cnt >= BLK_N) v.status = LS_FULL;
        else if (w.rlast < w.addr) v.status = LS_ORDER;
        else if (blk_cnt > 0 && w.addr <= blk_hi[blk_cnt-1]) v.status = LS_ORDER;
        else begin
          blk_lo[blk_cnt] = w.addr;
          blk_hi[blk_cnt] = w.rlast;
          blk_cc[blk_cnt] = w.cc;
          blk_cnt++;
        end
      end
      REQ_LOAD_EXC, REQ_LOAD_ADMIN: begin
        t = (w.req == REQ_LOAD_EXC) ? 0 : 1;
        if (rng_cnt[t] >= RNG_N) v.status = LS_FULL;
        else if (w.rlast < w.addr) v.status = LS_ORDER;
        else if (rng_cnt[t] > 0 && w.addr <= rng_hi[t][rng_cnt[t]-1]) v.status = LS_ORDER;
        else begin
          rng_lo[t][rng_cnt[t]] = w.addr;
          rng_hi[t][rng_cnt[t]] = w.rlast;
          rng_cnt[t]++;
        end
      end
      REQ_LOAD_COND: begin
        if (w.cls == KEY_BAD) v.status = LS_ORDER;
        else if (cond_find(w.cls, w.cc) >= 0) v.status = LS_DUP;
        else if (cond_cnt >= COND_N) v.status = LS_FULL;
        else begin
          cond_cls[cond_cnt] = w.cls;
          cond_cc[cond_cnt] = (w.cls == KEY_COUNTRY) ? w.cc : 16'd0;
          cond_blk[cond_cnt] = w.blk;
          cond_old[cond_cnt] = w.old;
          cond_cnt++;
        end
      end
      REQ_CHECK: begin
        hit = blk_find(w.addr);
        v.found = (hit >= 0) ? blk_cc[hit] : NO_COUNTRY;
        if (r_admin && w.auth == r_level && !rng_find(1, w.addr)) v.reason = RSN_ADMIN;
        else if (rng_find(0, w.addr)) begin
          v.allowed = 1'b1;
          v.reason = RSN_EXCEPTION;
        end else if (r_patch) v.reason = RSN_PATCH;
        else if (!r_filter) begin
          v.allowed = 1'b1;
          v.reason = RSN_FILTER_OFF;
        end else if (w.byp) begin
          v.allowed = 1'b1;
          v.reason = RSN_BYPASS;
        end else begin
          e = (hit >= 0) ? cond_find(KEY_COUNTRY, v.found) : cond_find(KEY_NOMATCH, 16'd0);
          if (e < 0) e = cond_find(KEY_DEFAULT, 16'd0);
          if (e < 0) v.reason = RSN_NO_ENTRY;
          else if (cond_blk[e] && (cond_old[e] || w.newu)) v.reason = RSN_COND;
          else begin
            v.allowed = 1'b1;
            v.reason = RSN_COND_OK;
          end
        end
      end
      REQ_CLEAR: begin
        blk_cnt = 0;
        rng_cnt[0] = 0;
        rng_cnt[1] = 0;
        cond_cnt = 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic req_word_t mkw(logic [2:0] req, logic [31:0] addr, logic [31:0] rlast,
                                    logic [15:0] cc, logic [1:0] cls, logic blk, logic old,
                                    logic signed [7:0] auth);
    req_word_t w;
    w = '{req, addr, rlast, cc, cls, blk, old, 1'b0, auth, 1'b0};
    return w;
  endfunction

  function automatic verdict_t vd(logic a, logic [2:0] r, logic [15:0] f, logic [1:0] s);
    verdict_t v;
    v = '{a, r, f, s};
    return v;
  endfunction

  function automatic logic [15:0] pick_country();
    case ($urandom_range(0, 4))
      0: return "US";
      1: return "CN";
      2: return "RU";
      3: return "KR";
      default: return 16'($urandom);
    endcase
  endfunction

  // address near a loaded range edge, or anywhere
  function automatic logic [31:0] pick_addr();
    int t, i, n;
    logic [31:0] lo, hi;
    t = $urandom_range(0, 2);
    n = (t == 2) ? blk_cnt : rng_cnt[t];
    if (n == 0 || $urandom_range(0, 3) == 0) return $urandom;
    i = $urandom_range(0, n - 1);
    lo = (t == 2) ? blk_lo[i] : rng_lo[t][i];
    hi = (t == 2) ? blk_hi[i] : rng_hi[t][i];
    case ($urandom_range(0, 4))
      0: return lo - 1;
      1: return lo;
      2: return hi;
      3: return hi + 1;
      default: return lo + (hi - lo) / 2;
    endcase
  endfunction

  // ordered range load into table t (2 block, 0 exception, 1 admin), sometimes broken
  function automatic req_word_t range_word(int t);
    req_word_t w;
    longint lo, hi;
    w = mkw(t == 2 ? REQ_LOAD_BLOCK : (t == 0 ? REQ_LOAD_EXC : REQ_LOAD_ADMIN),
            $urandom, $urandom, pick_country(), 2'd0, 1'b0, 1'b0, 8'sd0);
    lo = next_free(t) + $urandom_range(0, 1 << 22);
    hi = lo + $urandom_range(0, 1 << 22);
    if ($urandom_range(0, 9) != 0 && hi <= 64'hFFFF_FFFF) begin
      w.addr = lo[31:0];
      w.rlast = hi[31:0];
    end
    return w;
  endfunction

  function automatic req_word_t random_word();
    req_word_t w;
    int k;
    w = mkw(REQ_CHECK, pick_addr(), $urandom, pick_country(), 2'($urandom_range(0, 3)),
            1'($urandom), 1'($urandom), 8'($urandom));
    w.newu = 1'($urandom);
    w.byp = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 1)) w.auth = r_level;
    k = $urandom_range(0, 99);
    if (k < 25) w = range_word(2);
    else if (k < 34) w = range_word(0);
    else if (k < 43) w = range_word(1);
    else if (k < 55) begin
      w.req = REQ_LOAD_COND;
      k = $urandom_range(0, 9);
      w.cls = (k < 7) ? KEY_COUNTRY : (k == 7 ? KEY_DEFAULT : (k == 8 ? KEY_NOMATCH : KEY_BAD));
    end else if (k == 55) w.req = REQ_CLEAR;
    else if (k == 56) w.req = 3'($urandom_range(6, 7));
    return w;
  endfunction

  // one word over the start/busy handshake, then its prediction
  task automatic send(req_word_t w, bit typed, verdict_t tv);
    int gap;
    verdict_t v;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= w.req;
    in_address <= w.addr;
    in_range_last <= w.rlast;
    in_country <= w.cc;
    in_key_class <= w.cls;
    in_block_flag <= w.blk;
    in_block_old_users <= w.old;
    in_new_user <= w.newu;
    in_auth_level <= w.auth;
    in_bypass <= w.byp;
    do @(posedge clk); while (busy);
    v = filter_verdict(w);
    verdict_q.insert(verdict_q.size(), typed ? tv : v);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ADMIN_CHECK: r_admin = data[0];
      CFG_PATCH: r_patch = data[0];
      CFG_FILTER: r_filter = data[0];
      CFG_ADMIN_LEVEL: r_level = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic a, logic p, logic f, logic [7:0] lvl);
    drain();
    cfg_write(CFG_ADMIN_CHECK, {7'd0, a});
    cfg_write(CFG_PATCH, {7'd0, p});
    cfg_write(CFG_FILTER, {7'd0, f});
    cfg_write(CFG_ADMIN_LEVEL, lvl);
    cfg_valid <= 1'b0;
  endtask

  task automatic report(string s);
    errors++;
    if (errors <= 10) $display("%s", s);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) report("unexpected result word");
      else begin
        e = verdict_q.pop_front();
        if (out_allowed !== e.allowed || out_reason !== e.reason ||
            out_found_country !== e.found || out_load_status !== e.status)
          report($sformatf({"mismatch: exp allowed %0b reason %0d country %h status %0d,",
                            " got %0b %0d %h %0d"},
                           e.allowed, e.reason, e.found, e.status, out_allowed, out_reason,
                           out_found_country, out_load_status));
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t rows[$];
    verdict_t zero_v, off_zz;
    req_word_t w;
    errors = 0;
    blk_cnt = 0;
    rng_cnt[0] = 0;
    rng_cnt[1] = 0;
    cond_cnt = 0;
    r_admin = 1'b0;
    r_patch = 1'b0;
    r_filter = 1'b0;
    r_level = 8'd0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_CHECK;
    in_address = '0;
    in_range_last = '0;
    in_country = '0;
    in_key_class = KEY_COUNTRY;
    in_block_flag = 1'b0;
    in_block_old_users = 1'b0;
    in_new_user = 1'b0;
    in_auth_level = '0;
    in_bypass = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ADMIN_CHECK;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    zero_v = vd(1'b0, RSN_EXCEPTION, 16'd0, LS_OK);
    off_zz = vd(1'b1, RSN_FILTER_OFF, NO_COUNTRY, LS_OK);
    // directed table, filter off after reset
    rows.insert(rows.size(), '{mkw(REQ_CHECK, 32'h0, 32'h0, 16'h0, KEY_COUNTRY, 0, 0, 8'sd0), 1,
                               off_zz});
    rows.insert(rows.size(), '{mkw(REQ_CHECK, '1, '1, '1, KEY_NOMATCH, 1, 1, -8'sd128), 1,
                               off_zz});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_BLOCK, 32'd10, 32'd20, "US", KEY_COUNTRY, 0, 0,
                                   8'sd0), 1, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_BLOCK, 32'd50, 32'd40, "CN", KEY_COUNTRY, 0, 0,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_ORDER)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_BLOCK, 32'd15, 32'd30, "CN", KEY_COUNTRY, 0, 0,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_ORDER)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_BLOCK, 32'd21, 32'd21, "CN", KEY_COUNTRY, 0, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_BLOCK, 32'hFFFF_FF00, '1, "RU", KEY_COUNTRY, 0, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_EXC, 32'd100, 32'd200, 16'h0, KEY_COUNTRY, 0, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_EXC, 32'd150, 32'd300, 16'h0, KEY_COUNTRY, 0, 0,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_ORDER)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_ADMIN, 32'd5, 32'd12, 16'h0, KEY_COUNTRY, 0, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_ADMIN, 32'd9, 32'd8, 16'h0, KEY_COUNTRY, 0, 0,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_ORDER)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, "US", KEY_COUNTRY, 1, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, "US", KEY_COUNTRY, 0, 1,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_DUP)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, "KR", KEY_DEFAULT, 0, 0,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, "CN", KEY_DEFAULT, 1, 1,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_DUP)});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, 16'h0, KEY_NOMATCH, 1, 1,
                                   8'sd0), 0, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_LOAD_COND, 32'd0, 32'd0, "RU", KEY_BAD, 1, 0,
                                   8'sd0), 1, vd(0, RSN_EXCEPTION, 16'd0, LS_ORDER)});
    rows.insert(rows.size(), '{mkw(REQ_CHECK, 32'd15, 32'd0, 16'h0, KEY_COUNTRY, 0, 0,
                                   8'sd127), 0, zero_v});
    rows.insert(rows.size(), '{mkw(3'd6, '1, '1, '1, KEY_BAD, 1, 1, -8'sd1), 1, zero_v});
    rows.insert(rows.size(), '{mkw(3'd7, '1, '1, '1, KEY_BAD, 1, 1, -8'sd1), 1, zero_v});
    rows.insert(rows.size(), '{mkw(REQ_CHECK, '1, 32'd0, 16'h0, KEY_COUNTRY, 0, 0, 8'sd0), 0,
                               zero_v});
    rows.insert(rows.size(), '{mkw(REQ_CLEAR, 32'd0, 32'd0, 16'h0, KEY_COUNTRY, 0, 0, 8'sd0), 1,
                               zero_v});
    rows.insert(rows.size(), '{mkw(REQ_CHECK, 32'd15, 32'd0, 16'h0, KEY_COUNTRY, 0, 0, 8'sd0), 1,
                               off_zz});
    foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].v);

    // random phases, each under its own register setting
    for (int p = 0; p < RND_PHASES; p++) begin
      if (p == 0) set_regs(1'b0, 1'b0, 1'b1, 8'h80);
      else if (p == 1) set_regs(1'b1, 1'b1, 1'b1, 8'h7F);
      else if (p == 2) set_regs(1'b1, 1'b0, 1'b0, 8'h00);
      else set_regs(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 4) != 0, 8'($urandom));
      for (int i = 0; i < RND_PER_PHASE; i++) begin
        w = random_word();
        send(w, 1'b0, zero_v);
      end
    end

    // long ordered block run, then fill the range and condition tables and overflow them
    set_regs(1'b1, 1'b0, 1'b1, 8'h7F);
    send(mkw(REQ_CLEAR, 32'd0, 32'd0, 16'h0, KEY_COUNTRY, 0, 0, 8'sd0), 1'b0, zero_v);
    for (int i = 0; i < FILL_BLK; i++)
      send(mkw(REQ_LOAD_BLOCK, 32'(i * 16), 32'(i * 16 + 7), pick_country(), KEY_COUNTRY, 0, 0,
               8'sd0), 1'b0, zero_v);
    for (int i = 0; i <= RNG_N; i++) begin
      send(mkw(REQ_LOAD_EXC, 32'(i * 4096), 32'(i * 4096 + 3), 16'h0, KEY_COUNTRY, 0, 0, 8'sd0),
           1'b0, zero_v);
      send(mkw(REQ_LOAD_ADMIN, 32'(i * 4096 + 8), 32'(i * 4096 + 200), 16'h0, KEY_COUNTRY, 0, 0,
               8'sd0), 1'b0, zero_v);
    end
    send(mkw(REQ_LOAD_COND, 32'd0, 32'd0, 16'h0, KEY_DEFAULT, 0, 0, 8'sd0), 1'b0, zero_v);
    send(mkw(REQ_LOAD_COND, 32'd0, 32'd0, 16'h0, KEY_NOMATCH, 1, 0, 8'sd0), 1'b0, zero_v);
    for (int i = 0; i < COND_N; i++)
      send(mkw(REQ_LOAD_COND, 32'd0, 32'd0, i == 0 ? 16'h5553 : 16'(16'h4100 + i), KEY_COUNTRY,
               1'($urandom), 1'($urandom), 8'sd0), 1'b0, zero_v);
    send(mkw(REQ_LOAD_COND, 32'd0, 32'd0, 16'h5553, KEY_COUNTRY, 0, 0, 8'sd0), 1'b0, zero_v);
    for (int i = 0; i < 40; i++) begin
      w = random_word();
      w.req = REQ_CHECK;
      w.addr = $urandom_range(0, FILL_BLK * 16 + 64);
      send(w, 1'b0, zero_v);
    end

    // let the last words come out
    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
